FILE: src/xxhash32_stream_defines.svh
// Assertion macros used by the xxHash32 stream core.
`ifndef XXHASH32_STREAM_DEFINES_SVH
`define XXHASH32_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, ignored while reset is asserted.
`define XXH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xxh32 assertion failed");
// Checked property that also holds through reset.
`define XXH_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("xxh32 assertion failed");
`else
`define XXH_ASSERT(label, clk, rst_n, prop)
`define XXH_ASSERT_NR(label, clk, prop)
`endif

`endif

FILE: src/xxh32_pkg.sv
// Shared constants, types and helper functions of the xxHash32 stream block.
`timescale 1ns / 1ps

package xxh32_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [0:0] REG_SEED = 1'b0;

    localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
    localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME5 = 32'h1656_67B1;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    // Rotate left by a constant amount in 1..31.
    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Starting value of a lane accumulator for the given seed.
    function automatic logic [31:0] lane_init(input logic [1:0] k, input logic [31:0] seed);
        logic [31:0] v;
        unique case (k)
            2'd0:    v = seed + PRIME1 + PRIME2;
            2'd1:    v = seed + PRIME2;
            2'd2:    v = seed;
            default: v = seed - PRIME1;
        endcase
        return v;
    endfunction

endpackage

FILE: src/xxh32_mul.sv
// Shared 32x32 multiplier with a registered low-half product.
`timescale 1ns / 1ps

module xxh32_mul (
    input  logic                i_clk,
    input  xxh32_pkg::t_mul_req i_req,
    output logic [31:0]         o_prod
);
    import xxh32_pkg::*;

    logic [31:0] low_prod;
    logic [31:0] r_prod;

    // Only the low half of the product is ever used by the hash.
    assign low_prod = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        r_prod <= low_prod;
    end

    assign o_prod = r_prod;

endmodule

FILE: src/xxh32_regs.sv
// APB-style configuration register file holding the hash seed.
`timescale 1ns / 1ps

module xxh32_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [xxh32_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [xxh32_pkg::DATA_W-1:0]  i_pwdata,
    output logic [xxh32_pkg::DATA_W-1:0]  o_prdata,
    output logic                          o_pready,
    output logic [31:0]                   o_seed
);
    import xxh32_pkg::*;

    logic [0:0]  reg_idx;
    logic        wr_en;
    logic [31:0] r_seed;

    assign reg_idx  = i_paddr[ADDR_W-1:2];
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (wr_en && (reg_idx == REG_SEED)) begin
            r_seed <= i_pwdata;
        end
    end

    assign o_prdata = (reg_idx == REG_SEED) ? r_seed : '0;
    assign o_seed   = r_seed;

endmodule

FILE: src/xxh32_core.sv
// Sequencer, stripe buffer and lane state of the xxHash32 stream block.
`timescale 1ns / 1ps
`include "xxhash32_stream_defines.svh"

module xxh32_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_seed,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_byte_present,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_hash_value,
    output xxh32_pkg::t_mul_req o_mul_req,
    input  logic [31:0]         i_mul_prod
);
    import xxh32_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FOLD_A,
        S_FOLD_B,
        S_FOLD_W,
        S_FIN_INIT,
        S_TAIL_A,
        S_TAIL_B,
        S_TAIL_W,
        S_AV_A,
        S_AV_B,
        S_AV_C,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [3:0]  r_fill;
    logic [31:0] r_len;
    logic        r_seen;
    logic        r_last;
    logic [1:0]  r_lane;
    logic [3:0]  r_pos;
    logic        r_wmode;
    logic [31:0] r_h;
    logic [31:0] r_acc [4];
    logic [31:0] r_buf [4];
    logic        r_out_valid;
    logic [31:0] r_out;

    logic [4:0]  fill_inc;
    logic [4:0]  pos_nx;
    logic        accept;
    logic        wmode;
    logic [1:0]  word_idx;
    logic [31:0] word_rd;
    logic [7:0]  byte_rd;
    logic [31:0] acc_cur;
    logic [31:0] merge;
    logic [31:0] sum_t;
    logic [31:0] av_x;
    logic        out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign fill_inc = {1'b0, r_fill} + 5'd1;
    assign pos_nx   = {1'b0, r_pos} + (r_wmode ? 5'd4 : 5'd1);
    assign wmode    = (({1'b0, r_pos} + 5'd4) <= {1'b0, r_fill});
    assign out_free = !r_out_valid || i_ready;

    // One read port on the stripe buffer: the lane word while folding, the tail word after.
    assign word_idx = ((r_state == S_FOLD_A) || (r_state == S_FOLD_B)) ? r_lane : r_pos[3:2];
    assign word_rd  = r_buf[word_idx];
    assign byte_rd  = word_rd[{r_pos[1:0], 3'b000} +: 8];

    assign acc_cur = r_seen ? r_acc[r_lane] : lane_init(r_lane, i_seed);
    assign merge   = rotl(r_acc[0], 1) + rotl(r_acc[1], 7)
                   + rotl(r_acc[2], 12) + rotl(r_acc[3], 18);
    assign sum_t   = ((r_state == S_FOLD_B) ? acc_cur : r_h) + i_mul_prod;
    assign av_x    = i_mul_prod ^ (i_mul_prod >> 13);

    // Operand selection for the shared multiplier.
    always_comb begin
        o_mul_req = '0;
        unique case (r_state)
            S_FOLD_A: begin
                o_mul_req.a = word_rd;
                o_mul_req.b = PRIME2;
            end
            S_FOLD_B: begin
                o_mul_req.a = rotl(sum_t, 13);
                o_mul_req.b = PRIME1;
            end
            S_TAIL_A: begin
                o_mul_req.a = wmode ? word_rd : {24'd0, byte_rd};
                o_mul_req.b = wmode ? PRIME3 : PRIME5;
            end
            S_TAIL_B: begin
                o_mul_req.a = r_wmode ? rotl(sum_t, 17) : rotl(sum_t, 11);
                o_mul_req.b = r_wmode ? PRIME4 : PRIME1;
            end
            S_AV_A: begin
                o_mul_req.a = r_h ^ (r_h >> 15);
                o_mul_req.b = PRIME2;
            end
            S_AV_B: begin
                o_mul_req.a = av_x;
                o_mul_req.b = PRIME3;
            end
            default: begin
                o_mul_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_seen      <= 1'b0;
            r_last      <= 1'b0;
            r_lane      <= '0;
            r_pos       <= '0;
            r_wmode     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded below instead.
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last;
                        if (i_byte_present) begin
                            r_buf[r_fill[3:2]][{r_fill[1:0], 3'b000} +: 8] <= i_data_byte;
                            r_fill <= fill_inc[3:0];
                            r_len  <= r_len + 32'd1;
                        end
                        if (i_byte_present && fill_inc[4]) begin
                            r_lane  <= '0;
                            r_state <= S_FOLD_A;
                        end else if (i_last) begin
                            r_state <= S_FIN_INIT;
                        end
                    end
                end
                S_FOLD_A: begin
                    // The previous lane's product is still in the multiplier register.
                    if (r_lane != 2'd0) begin
                        r_acc[r_lane - 2'd1] <= i_mul_prod;
                    end
                    r_state <= S_FOLD_B;
                end
                S_FOLD_B: begin
                    if (r_lane == 2'd3) begin
                        r_state <= S_FOLD_W;
                    end else begin
                        r_lane  <= r_lane + 2'd1;
                        r_state <= S_FOLD_A;
                    end
                end
                S_FOLD_W: begin
                    r_acc[3] <= i_mul_prod;
                    r_seen   <= 1'b1;
                    r_state  <= r_last ? S_FIN_INIT : S_IDLE;
                end
                S_FIN_INIT: begin
                    r_h     <= (r_seen ? merge : (i_seed + PRIME5)) + r_len;
                    r_pos   <= '0;
                    r_state <= (r_fill != 4'd0) ? S_TAIL_A : S_AV_A;
                end
                S_TAIL_A: begin
                    r_wmode <= wmode;
                    r_state <= S_TAIL_B;
                end
                S_TAIL_B: begin
                    r_state <= S_TAIL_W;
                end
                S_TAIL_W: begin
                    r_h     <= i_mul_prod;
                    r_pos   <= pos_nx[3:0];
                    r_state <= (pos_nx < {1'b0, r_fill}) ? S_TAIL_A : S_AV_A;
                end
                S_AV_A: begin
                    r_state <= S_AV_B;
                end
                S_AV_B: begin
                    r_state <= S_AV_C;
                end
                S_AV_C: begin
                    r_h     <= i_mul_prod ^ (i_mul_prod >> 16);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out       <= r_h;
                        r_out_valid <= 1'b1;
                        r_fill      <= '0;
                        r_len       <= '0;
                        r_seen      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

    `XXH_ASSERT(a_fold_after_wrap, i_clk, i_rst_n, (r_state == S_FOLD_A) |-> (r_fill == 4'd0))
    `XXH_ASSERT(a_tail_in_range, i_clk, i_rst_n, (r_state == S_TAIL_A) |-> (r_pos < r_fill))
    `XXH_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
    `XXH_ASSERT_NR(a_reset_idle, i_clk, (!i_rst_n) |=> ((r_state == S_IDLE) && !r_out_valid))

endmodule

FILE: src/xxhash32_stream.sv
// Top level of the streaming xxHash32 block: register port, sequencer and shared multiplier.
//
// Usage: a message is sent as a series of requests on the input channel (i_valid/o_ready),
// one byte per request in i_data_byte when i_byte_present is high. A request with
// i_byte_present low carries no byte; with i_last it ends the message, which is how an empty message is sent.
// The request with i_last high ends the message, and one request on the output channel
// (o_valid/i_ready) later carries the 32-bit hash in o_hash_value. The seed is written
// through the APB-style port at byte address 0 while the block is idle.
// Sequence: a byte that does not complete a 16-byte stripe goes straight into the buffer.
// The byte that completes a stripe starts a fold: the four lane rounds run two multiplies
// each on the one shared multiplier, one step per multiply, and a write-back step follows.
// Finishing a message runs an init step, then the two multiplies and a write-back step
// per tail word and per tail byte, then the avalanche and an output step before the hash
// is offered. The input channel is not ready while a stripe folds or a message finishes.
// Reset (synchronous, active low) clears the seed, the byte count and the output valid.
// If the receiver stalls, the finished hash waits in the output register; the block keeps
// taking requests until the next message needs that register, and then holds there.
`timescale 1ns / 1ps

module xxhash32_stream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [xxh32_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [xxh32_pkg::DATA_W-1:0]  i_pwdata,
    output logic [xxh32_pkg::DATA_W-1:0]  o_prdata,
    output logic                          o_pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_byte_present,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_hash_value
);
    import xxh32_pkg::*;

    logic [31:0] seed;
    t_mul_req    mul_req;
    logic [31:0] mul_prod;

    // Configuration registers; the seed is used by the first stripe fold, or by a message with no stripe.
    xxh32_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_seed    (seed)
    );

    // Sequencer with the stripe buffer, lane accumulators and output register.
    xxh32_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed         (seed),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hash_value   (o_hash_value),
        .o_mul_req      (mul_req),
        .i_mul_prod     (mul_prod)
    );

    // The single multiplier shared by lane rounds, tail folding and the avalanche.
    xxh32_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

endmodule

FILE: tb/xxhash32_stream_checker.sv
// Checker that predicts the xxHash32 digest of each observed message and compares results.
`timescale 1ns / 1ps

module xxhash32_stream_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [xxh32_pkg::ADDR_W-1:0] i_paddr,
    input  logic [xxh32_pkg::DATA_W-1:0] i_pwdata,
    input  logic [xxh32_pkg::DATA_W-1:0] i_prdata,
    input  logic                         i_pready,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_byte_present,
    input  logic                         i_last,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [31:0]                  i_hash_value,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending
);

    localparam logic [31:0] PRIME_1 = 32'h9E37_79B1;
    localparam logic [31:0] PRIME_2 = 32'h85EB_CA77;
    localparam logic [31:0] PRIME_3 = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME_4 = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME_5 = 32'h1656_67B1;

    localparam logic [xxh32_pkg::ADDR_W-1:0] SEED_ADDR = {xxh32_pkg::REG_SEED, 2'b00};

    logic [31:0] seed_q;
    logic [31:0] lane_q [4];
    logic [7:0]  stripe_q [16];
    int unsigned fill_q;
    logic [31:0] length_q;
    bit          stripe_done_q;
    logic [31:0] digest_expected_q [$];
    int unsigned fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
        logic [63:0] both;
        both = {v, v} << n;
        return both[63:32];
    endfunction

    // Little-endian word built from four buffered bytes.
    function automatic logic [31:0] stripe_word(input int unsigned p);
        return {stripe_q[p + 3], stripe_q[p + 2], stripe_q[p + 1], stripe_q[p]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t: %s mismatch: got %08h, expected %08h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : observe
        logic [31:0] h;
        int unsigned p;
        if (!i_rst_n) begin
            seed_q        = '0;
            fill_q        = 0;
            length_q      = '0;
            stripe_done_q = 1'b0;
            digest_expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == SEED_ADDR) begin
                if (i_pwrite) begin
                    seed_q = i_pwdata;
                end else if (i_prdata !== seed_q) begin
                    report_mismatch("seed readback", i_prdata, seed_q);
                end
            end

            // A hash can never leave on the edge that takes its last request,
            // so results are checked before this edge's request is folded in.
            if (i_out_valid && i_out_ready) begin
                if (digest_expected_q.size() == 0) begin
                    report_mismatch("unrequested hash", i_hash_value, 32'h0);
                end else begin
                    h = digest_expected_q.pop_front();
                    if (i_hash_value !== h) begin
                        report_mismatch("hash_value", i_hash_value, h);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (i_byte_present) begin
                    stripe_q[fill_q] = i_data_byte;
                    fill_q++;
                    length_q++;
                    if (fill_q == 16) begin
                        // Lanes pick up the seed when the first stripe folds.
                        if (!stripe_done_q) begin
                            lane_q[0]     = seed_q + PRIME_1 + PRIME_2;
                            lane_q[1]     = seed_q + PRIME_2;
                            lane_q[2]     = seed_q;
                            lane_q[3]     = seed_q - PRIME_1;
                            stripe_done_q = 1'b1;
                        end
                        for (int k = 0; k < 4; k++) begin
                            lane_q[k] = rol32(lane_q[k] + stripe_word(4 * k) * PRIME_2, 13)
                                        * PRIME_1;
                        end
                        fill_q = 0;
                    end
                end
                if (i_last) begin
                    if (stripe_done_q) begin
                        h = rol32(lane_q[0], 1) + rol32(lane_q[1], 7)
                          + rol32(lane_q[2], 12) + rol32(lane_q[3], 18);
                    end else begin
                        h = seed_q + PRIME_5;
                    end
                    h += length_q;
                    p = 0;
                    while (p + 4 <= fill_q) begin
                        h += stripe_word(p) * PRIME_3;
                        h = rol32(h, 17) * PRIME_4;
                        p += 4;
                    end
                    while (p < fill_q) begin
                        h += {24'h0, stripe_q[p]} * PRIME_5;
                        h = rol32(h, 11) * PRIME_1;
                        p++;
                    end
                    h ^= h >> 15;
                    h *= PRIME_2;
                    h ^= h >> 13;
                    h *= PRIME_3;
                    h ^= h >> 16;
                    digest_expected_q.push_back(h);
                    fill_q        = 0;
                    length_q      = '0;
                    stripe_done_q = 1'b0;
                end
            end
        end
        o_pending <= digest_expected_q.size();
    end

endmodule

FILE: tb/xxhash32_stream_tb.sv
// Testbench top for the streaming xxHash32 block: stimulus, seed programming and verdict.
`timescale 1ns / 1ps

module xxhash32_stream_tb;

    localparam logic [xxh32_pkg::ADDR_W-1:0] SEED_ADDR = {xxh32_pkg::REG_SEED, 2'b00};

    localparam int unsigned PHASES          = 6;
    localparam int unsigned HOLD_PHASE      = 2;
    localparam int unsigned ITEMS_PER_PHASE = 280;
    localparam int unsigned HOLD_MESSAGES   = 40;
    localparam int unsigned LONG_HOLD       = 300;
    // Covers the longest finishing sequence plus a stripe fold.
    localparam int unsigned SETTLE_CYCLES   = 40;
    // The longest quiet stretch of a correct run is the long receiver hold.
    localparam int unsigned QUIET_LIMIT     = 3000;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [xxh32_pkg::ADDR_W-1:0] paddr;
    logic [xxh32_pkg::DATA_W-1:0] pwdata;
    logic [xxh32_pkg::DATA_W-1:0] prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_ready;
    logic [7:0]                   data_byte;
    logic                         byte_present;
    logic                         last_flag;
    logic                         out_valid;
    logic                         out_ready;
    logic [31:0]                  hash_value;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned requests_sent = 0;
    int unsigned quiet_cycles  = 0;

    // Both sides idle at random while this is set; the last phase clears it.
    bit idle_en  = 1'b1;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    xxhash32_stream dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_pready       (pready),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_data_byte    (data_byte),
        .i_byte_present (byte_present),
        .i_last         (last_flag),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_hash_value   (hash_value)
    );

    xxhash32_stream_checker u_digest_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_byte_present (byte_present),
        .i_last         (last_flag),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_hash_value   (hash_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Offers one request and returns on the edge that accepts it. An optional
    // gap comes first; valid is only lowered at the start of a gap, so a request
    // that has been offered is held until it is taken. Requests that carry
    // neither a byte nor the end of a message are ignored by the block and do
    // not count toward the total.
    task automatic send_request(input logic [7:0] b, input logic present, input logic is_last);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        last_flag    <= is_last;
        do @(posedge clk); while (!in_ready);
        if (present || is_last) begin
            requests_sent++;
        end
    endtask

    // Sends a whole message of random bytes. The final byte carries the last flag
    // half the time; otherwise an empty request closes the message, which is also
    // how an empty message is sent. Empty requests are sprinkled in as noise.
    task automatic send_message(input int unsigned n_bytes, input int unsigned noise_pct);
        bit byte_on_last;
        byte_on_last = (n_bytes != 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned k = 0; k < n_bytes; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_request(8'($urandom_range(0, 255)), 1'b1, byte_on_last && k == n_bytes - 1);
        end
        if (!byte_on_last) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Mostly short messages to hit every tail length, some with a few stripes,
    // and a handful long enough to run several folds back to back.
    function automatic int unsigned rand_length();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return $urandom_range(0, 15);
        end else if (pick < 9) begin
            return $urandom_range(16, 47);
        end
        return $urandom_range(48, 100);
    endfunction

    // Stops offering, waits for every outstanding hash, then lets the block settle
    // so that nothing is still in flight when the seed changes.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the seed register and reads it straight back. The read shares the
    // select of the write, so the two transfers run back to back.
    task automatic program_seed(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stall bursts while idling is on, a steady ready
    // otherwise, and one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int unsigned span;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                span = idle_en ? $urandom_range(1, 25) : 1;
                repeat (span) @(posedge clk);
            end
        end
    end

    // Ends a run that has stopped moving: neither channel nor the register
    // port has done anything for far longer than any correct run can take.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL xxhash32_stream");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] seed_plan [PHASES];
        int unsigned target;

        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        byte_present <= 1'b0;
        last_flag    <= 1'b0;

        // Seed extremes, a seed that makes the fourth lane start at zero, and
        // random seeds.
        seed_plan[0] = 32'hFFFF_FFFF;
        seed_plan[1] = 32'h0000_0000;
        seed_plan[2] = $urandom();
        seed_plan[3] = 32'h9E37_79B1;
        seed_plan[4] = $urandom();
        seed_plan[5] = $urandom();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages under the reset seed. First the empty message, then
        // a single byte that also ends the message.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b1, 1'b1);
        // An ignored empty request inside a message, and a message closed by an
        // empty request after its byte.
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1);
        // Exactly one stripe, the last byte completing it, so the tail is empty.
        // Byte values 00, 11 .. FF drive every data bit both ways.
        for (int unsigned k = 0; k < 16; k++) begin
            send_request(8'(k * 17), 1'b1, k == 15);
        end

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            wait_for_idle();
            program_seed(seed_plan[ph]);
            if (ph == HOLD_PHASE) begin
                // Short messages while the receiver holds off fill the output
                // register and make the block stall its input.
                hold_req = 1'b1;
                repeat (HOLD_MESSAGES) send_message($urandom_range(0, 3), 0);
            end
            if (ph == PHASES - 1) begin
                idle_en = 1'b0;
            end
            target = requests_sent + ITEMS_PER_PHASE;
            while (requests_sent < target) begin
                send_message(rand_length(), 8);
            end
        end

        wait_for_idle();
        if (fail_count == 0) begin
            $display("PASS xxhash32_stream");
        end else begin
            $display("FAIL xxhash32_stream");
        end
        $finish;
    end

endmodule

FILE: xxhash32_stream.f
+incdir+src
src/xxh32_pkg.sv
src/xxh32_mul.sv
src/xxh32_regs.sv
src/xxh32_core.sv
src/xxhash32_stream.sv
tb/xxhash32_stream_checker.sv
tb/xxhash32_stream_tb.sv
